// File: hw/rtl/epc_pkg.sv
package epc_pkg;

  // field widths
  localparam int POS_W  = 16;
  localparam int VEL_W  = 16;
  localparam int MASS_W = 8;
  localparam int RAD_W  = 12;

  // radius after reset, 1/16 pixel units
  localparam logic [RAD_W-1:0] RADIUS_RESET = 12'd160;

  // quotient bits of the rounded velocity change (magnitude below 2^18 on a hit)
  localparam int Q_W   = 19;
  // dividend (2*|num| + den) and doubled divisor widths
  localparam int DIV_W = 54;
  localparam int DEN_W = 36;
  // number of parallel velocity lanes
  localparam int LANES = 4;

  typedef struct packed {
    logic signed [POS_W-1:0]  first_pos_x;
    logic signed [POS_W-1:0]  first_pos_y;
    logic signed [VEL_W-1:0]  first_vel_x;
    logic signed [VEL_W-1:0]  first_vel_y;
    logic        [MASS_W-1:0] first_mass;
    logic signed [POS_W-1:0]  second_pos_x;
    logic signed [POS_W-1:0]  second_pos_y;
    logic signed [VEL_W-1:0]  second_vel_x;
    logic signed [VEL_W-1:0]  second_vel_y;
    logic        [MASS_W-1:0] second_mass;
  } pair_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] new_first_vel_x;
    logic signed [VEL_W-1:0] new_first_vel_y;
    logic signed [VEL_W-1:0] new_second_vel_x;
    logic signed [VEL_W-1:0] new_second_vel_y;
    logic                    collided;
  } result_t;

  // the four velocities travelling down the pipe: v1x, v1y, v2x, v2y
  typedef logic [LANES-1:0][VEL_W-1:0] vel4_t;

endpackage

// File: hw/rtl/elastic_pair_collision.sv
// channel  | ports                    | handshake
// ---------+--------------------------+--------------------------------------
// pair     | start, busy, pair        | item taken when start & !busy
// result   | done, result             | one-cycle strobe, no back-pressure
// config   | cfg_valid, cfg_ready,    | write when cfg_valid & cfg_ready
//          | cfg_data                 |
//
// One item is taken every cycle; busy stays low.
// Each result passes through the five arithmetic stages, the divider load
// stage, the nineteen-step restoring divider (one quotient bit per stage)
// and the output register.
// Reset clears the valid bits and sets the radius to 160; data needs none.
// The receiver cannot stall, so the pipe never holds.
module elastic_pair_collision
  import epc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pair_t            pair,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RAD_W-1:0] cfg_data,
  output logic             done,
  output result_t          result
);

  // saturate to the 16-bit velocity range
  function automatic logic [VEL_W-1:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) begin
      return 16'h7fff;
    end else if (v < -21'sd32768) begin
      return 16'h8000;
    end else begin
      return v[VEL_W-1:0];
    end
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // radius register
  logic [RAD_W-1:0] radius;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  logic [RAD_W:0] diameter;
  assign diameter = {radius, 1'b0};

  // stage a: differences and contact limit
  logic               a_vld;
  logic signed [16:0] a_dx, a_dy, a_wx, a_wy;
  logic [25:0]        a_lim;
  logic [MASS_W-1:0]  a_m1, a_m2;
  vel4_t              a_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    a_dx  <= {pair.first_pos_x[15], pair.first_pos_x} - {pair.second_pos_x[15], pair.second_pos_x};
    a_dy  <= {pair.first_pos_y[15], pair.first_pos_y} - {pair.second_pos_y[15], pair.second_pos_y};
    a_wx  <= {pair.first_vel_x[15], pair.first_vel_x} - {pair.second_vel_x[15], pair.second_vel_x};
    a_wy  <= {pair.first_vel_y[15], pair.first_vel_y} - {pair.second_vel_y[15], pair.second_vel_y};
    a_lim <= diameter * diameter;
    a_m1  <= pair.first_mass;
    a_m2  <= pair.second_mass;
    a_vel <= {pair.second_vel_y, pair.second_vel_x, pair.first_vel_y, pair.first_vel_x};
  end

  // stage b: squares and dot terms
  logic               b_vld;
  logic signed [33:0] b_xx, b_yy, b_wdx, b_wdy;
  logic signed [16:0] b_dx, b_dy;
  logic [25:0]        b_lim;
  logic [MASS_W-1:0]  b_m1, b_m2;
  vel4_t              b_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_xx  <= a_dx * a_dx;
    b_yy  <= a_dy * a_dy;
    b_wdx <= a_wx * a_dx;
    b_wdy <= a_wy * a_dy;
    b_dx  <= a_dx;
    b_dy  <= a_dy;
    b_lim <= a_lim;
    b_m1  <= a_m1;
    b_m2  <= a_m2;
    b_vel <= a_vel;
  end

  // stage c: squared distance, dot product, collision test
  logic signed [34:0] c_d2_full, c_dot_full;
  assign c_d2_full  = 35'(b_xx) + 35'(b_yy);
  assign c_dot_full = 35'(b_wdx) + 35'(b_wdy);

  logic               c_vld, c_hit;
  logic [25:0]        c_d2;
  logic signed [30:0] c_dot;
  logic signed [13:0] c_dx, c_dy;
  logic [MASS_W:0]    c_msum;
  logic [MASS_W-1:0]  c_m1, c_m2;
  vel4_t              c_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  // on a hit |d| < 8190 and |dot| < 2^30, so the narrowed copies are exact
  always_ff @(posedge clk) begin
    c_hit  <= ($unsigned(c_d2_full) < {9'd0, b_lim}) && c_dot_full[34];
    c_d2   <= c_d2_full[25:0];
    c_dot  <= c_dot_full[30:0];
    c_dx   <= b_dx[13:0];
    c_dy   <= b_dy[13:0];
    c_msum <= {1'b0, b_m1} + {1'b0, b_m2};
    c_m1   <= b_m1;
    c_m2   <= b_m2;
    c_vel  <= b_vel;
  end

  // stage d: scaled dot products and denominator
  logic               d_vld, d_hit, d_go;
  logic signed [39:0] d_k1, d_k2;
  logic [34:0]        d_den;
  logic signed [13:0] d_dx, d_dy;
  vel4_t              d_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_k1  <= 40'(c_dot * $signed({1'b0, c_m2, 1'b0}));
    d_k2  <= 40'(c_dot * $signed({1'b0, c_m1, 1'b0}));
    d_den <= c_msum * c_d2;
    d_hit <= c_hit;
    d_go  <= c_hit && (c_msum != '0);
    d_dx  <= c_dx;
    d_dy  <= c_dy;
    d_vel <= c_vel;
  end

  // stage e: numerators as magnitude and sign; lanes of the second particle use -d
  logic signed [53:0] e_prod [LANES];
  always_comb begin
    e_prod[0] = d_k1 * d_dx;
    e_prod[1] = d_k1 * d_dy;
    e_prod[2] = d_k2 * d_dx;
    e_prod[3] = d_k2 * d_dy;
  end

  logic              e_vld, e_hit, e_go;
  logic [DIV_W-1:0]  e_mag [LANES];
  logic [LANES-1:0]  e_neg;
  logic [34:0]       e_den;
  vel4_t             e_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      e_mag[l] <= e_prod[l][53] ? $unsigned(-e_prod[l]) : $unsigned(e_prod[l]);
      e_neg[l] <= e_prod[l][53] ^ (l >= 2);
    end
    e_den <= d_den;
    e_hit <= d_hit;
    e_go  <= d_go;
    e_vel <= d_vel;
  end

  // divider pipe: index 0 is loaded with 2*|num| + den over 2*den
  logic             dv_vld [Q_W+1];
  logic             dv_hit [Q_W+1];
  logic             dv_go  [Q_W+1];
  logic [DIV_W-1:0] dv_rem [Q_W+1][LANES];
  logic [Q_W-1:0]   dv_q   [Q_W+1][LANES];
  logic [LANES-1:0] dv_neg [Q_W+1];
  logic [DEN_W-1:0] dv_den [Q_W+1];
  vel4_t            dv_vel [Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      dv_rem[0][l] <= {e_mag[l][DIV_W-2:0], 1'b0} + DIV_W'(e_den);
      dv_q[0][l]   <= '0;
    end
    dv_neg[0] <= e_neg;
    dv_den[0] <= {e_den, 1'b0};
    dv_hit[0] <= e_hit;
    dv_go[0]  <= e_go;
    dv_vel[0] <= e_vel;
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar s = 0; s < Q_W; s++) begin : g_div
    localparam int BIT = Q_W - 1 - s;

    logic [DIV_W-1:0] shifted;
    assign shifted = DIV_W'(dv_den[s]) << BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[s+1] <= 1'b0;
      end else begin
        dv_vld[s+1] <= dv_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        if (dv_rem[s][l] >= shifted) begin
          dv_rem[s+1][l]   <= dv_rem[s][l] - shifted;
          dv_q[s+1][l]     <= dv_q[s][l] | (Q_W'(1) << BIT);
        end else begin
          dv_rem[s+1][l]   <= dv_rem[s][l];
          dv_q[s+1][l]     <= dv_q[s][l];
        end
      end
      dv_neg[s+1] <= dv_neg[s];
      dv_den[s+1] <= dv_den[s];
      dv_hit[s+1] <= dv_hit[s];
      dv_go[s+1]  <= dv_go[s];
      dv_vel[s+1] <= dv_vel[s];
    end
  end

  // apply signed change and saturate
  logic signed [20:0] fin_delta [LANES];
  logic signed [20:0] fin_new   [LANES];
  logic [VEL_W-1:0]   fin_vel   [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fin_delta[l] = dv_neg[Q_W][l] ? -$signed({2'b00, dv_q[Q_W][l]})
                                    :  $signed({2'b00, dv_q[Q_W][l]});
      fin_new[l]   = $signed({{5{dv_vel[Q_W][l][VEL_W-1]}}, dv_vel[Q_W][l]}) - fin_delta[l];
      fin_vel[l]   = dv_go[Q_W] ? sat16(fin_new[l]) : dv_vel[Q_W][l];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    result.new_first_vel_x  <= fin_vel[0];
    result.new_first_vel_y  <= fin_vel[1];
    result.new_second_vel_x <= fin_vel[2];
    result.new_second_vel_y <= fin_vel[3];
    result.collided         <= dv_hit[Q_W];
  end

endmodule

// File: tb/elastic_pair_collision_test.sv
module elastic_pair_collision_test;
  import epc_pkg::*;

  // expected velocity updates, oldest first
  class collision_board;
    result_t           pending[$];
    logic [RAD_W-1:0]  radius;
    int                errors;

    function new();
      radius = RADIUS_RESET;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("error: %s got %0d want %0d", what, got, want);
      errors++;
    endtask

    // rounded quotient, ties away from zero; den > 0
    function longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
    endfunction

    function logic signed [VEL_W-1:0] clip(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[VEL_W-1:0];
    endfunction

    // work out the velocities for an accepted pair
    function void note_pair(pair_t p);
      longint dx, dy, wx, wy, dist2, lim, dot, m1, m2, den, k1, k2;
      longint n1x, n1y, n2x, n2y;
      result_t r;
      dx = longint'(p.first_pos_x) - longint'(p.second_pos_x);
      dy = longint'(p.first_pos_y) - longint'(p.second_pos_y);
      wx = longint'(p.first_vel_x) - longint'(p.second_vel_x);
      wy = longint'(p.first_vel_y) - longint'(p.second_vel_y);
      m1 = longint'(p.first_mass);
      m2 = longint'(p.second_mass);
      dist2 = dx * dx + dy * dy;
      lim = 4 * longint'(radius) * longint'(radius);
      dot = wx * dx + wy * dy;
      n1x = p.first_vel_x;
      n1y = p.first_vel_y;
      n2x = p.second_vel_x;
      n2y = p.second_vel_y;
      r.collided = (dist2 < lim) && (dot < 0);
      if (r.collided && (m1 + m2) != 0) begin
        den = (m1 + m2) * dist2;
        k1 = 2 * m2 * dot;
        k2 = 2 * m1 * dot;
        n1x -= round_div(k1 * dx, den);
        n1y -= round_div(k1 * dy, den);
        n2x -= round_div(k2 * (-dx), den);
        n2y -= round_div(k2 * (-dy), den);
      end
      r.new_first_vel_x = clip(n1x);
      r.new_first_vel_y = clip(n1y);
      r.new_second_vel_x = clip(n2x);
      r.new_second_vel_y = clip(n2y);
      pending = {pending, r};
    endfunction

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("result with no pair waiting, count", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.new_first_vel_x !== want.new_first_vel_x)
        report("new_first_vel_x", got.new_first_vel_x, want.new_first_vel_x);
      if (got.new_first_vel_y !== want.new_first_vel_y)
        report("new_first_vel_y", got.new_first_vel_y, want.new_first_vel_y);
      if (got.new_second_vel_x !== want.new_second_vel_x)
        report("new_second_vel_x", got.new_second_vel_x, want.new_second_vel_x);
      if (got.new_second_vel_y !== want.new_second_vel_y)
        report("new_second_vel_y", got.new_second_vel_y, want.new_second_vel_y);
      if (got.collided !== want.collided)
        report("collided", got.collided, want.collided);
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  pair_t            pair;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [RAD_W-1:0] cfg_data;
  logic             done;
  result_t          result;

  collision_board board;

  elastic_pair_collision dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pair(pair),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // overall time limit
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  // offer one item, keep start high afterwards
  task automatic send_pair(pair_t p);
    pair <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_pair(p);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drain the pipe, then write the radius
  task automatic set_radius(logic [RAD_W-1:0] r);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_data <= r;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.radius = r;
  endtask

  function automatic pair_t make_pair(logic [RAD_W-1:0] r, bit near);
    pair_t p;
    int span;
    p = pair_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
    p.first_mass = 8'($urandom_range(1, 255));
    p.second_mass = 8'($urandom_range(1, 255));
    if (near) begin
      span = 2 * int'(r) + 2;
      p.first_pos_x = 16'($urandom_range(0, 40000) - 20000);
      p.first_pos_y = 16'($urandom_range(0, 40000) - 20000);
      p.second_pos_x = 16'(p.first_pos_x + ($urandom_range(0, 2 * span) - span));
      p.second_pos_y = 16'(p.first_pos_y + ($urandom_range(0, 2 * span) - span));
      // slow velocities now and then, so the update stays in range
      if ($urandom_range(0, 1)) begin
        p.first_vel_x = 16'($urandom_range(0, 8192) - 4096);
        p.first_vel_y = 16'($urandom_range(0, 8192) - 4096);
        p.second_vel_x = 16'($urandom_range(0, 8192) - 4096);
        p.second_vel_y = 16'($urandom_range(0, 8192) - 4096);
      end
    end
    return p;
  endfunction

  function automatic pair_t head_on(int sep, int va, int vb, int ma, int mb);
    pair_t p;
    p = '0;
    p.second_pos_x = 16'(sep);
    p.first_vel_x = 16'(va);
    p.second_vel_x = 16'(vb);
    p.first_mass = 8'(ma);
    p.second_mass = 8'(mb);
    return p;
  endfunction

  // random burst traffic
  task automatic run_random(int count);
    int burst;
    int k;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && k < count) begin
        send_pair(make_pair(board.radius, $urandom_range(0, 9) < 7));
        burst--;
        k++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [RAD_W-1:0] radii[5];
    pair_t p;
    board = new();
    rst = 1'b1;
    start = 1'b0;
    pair = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_radius(RADIUS_RESET);
    // coincident particles
    p = head_on(0, 4096, -4096, 10, 10);
    send_pair(p);
    // head on, equal masses, and the saturating extremes
    send_pair(head_on(16, 4096, -4096, 1, 1));
    send_pair(head_on(16, 32767, -32768, 255, 255));
    send_pair(head_on(16, 32767, -32768, 1, 255));
    send_pair(head_on(-16, -32768, 32767, 255, 1));
    // receding pair: no collision
    send_pair(head_on(16, -4096, 4096, 5, 7));
    // just inside and just outside contact distance
    send_pair(head_on(319, 100, -100, 3, 3));
    send_pair(head_on(320, 100, -100, 3, 3));
    // zero masses
    send_pair(head_on(32, 4096, 0, 0, 0));
    send_pair(head_on(32, 4096, 0, 0, 9));
    send_pair(head_on(32, 4096, 0, 9, 0));
    // position extremes far apart, and all ones and zeros
    p = '0;
    p.first_pos_x = 32767;
    p.first_pos_y = 32767;
    p.second_pos_x = -32768;
    p.second_pos_y = -32768;
    p.first_mass = 255;
    p.second_mass = 1;
    send_pair(p);
    send_pair('1);
    send_pair('0);
    // diagonal approach
    p = '0;
    p.second_pos_x = 100;
    p.second_pos_y = 60;
    p.first_vel_x = 3000;
    p.first_vel_y = 2000;
    p.second_vel_x = -1000;
    p.first_mass = 17;
    p.second_mass = 200;
    send_pair(p);
    pause(3);

    radii[0] = RADIUS_RESET;
    radii[1] = 12'd1;
    radii[2] = 12'd4095;
    radii[3] = 12'($urandom_range(2, 4094));
    radii[4] = 12'd40;
    foreach (radii[i]) begin
      if (i != 0) set_radius(radii[i]);
      if (i == 2) send_pair(head_on(-8189, 4096, -4096, 1, 1));
      run_random(205);
    end

    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
